// ===== hdl/cms_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar minute stepper.
// No dependencies.
package cms_pkg;

  localparam logic [1:0] OP_ADD_MINUTE = 2'd0;
  localparam logic [1:0] OP_SUB_MINUTE = 2'd1;
  localparam logic [1:0] OP_TO_UTC     = 2'd2;

  localparam logic [1:0] DST_STANDARD = 2'd0;
  localparam logic [1:0] DST_SUMMER   = 2'd1;
  localparam logic [1:0] DST_UNKNOWN  = 2'd2;
  localparam logic [1:0] DST_UTC      = 2'd3;

  localparam logic [11:0] YEAR_FIRST = 12'd1900;
  localparam logic [11:0] YEAR_LAST  = 12'd2299;

  localparam logic [5:0] MINUTE_LAST = 6'd59;
  localparam logic [4:0] HOUR_LAST   = 5'd23;
  localparam logic [2:0] WEEKDAY_MON = 3'd1;
  localparam logic [2:0] WEEKDAY_SUN = 3'd7;
  localparam logic [3:0] MONTH_JAN   = 4'd1;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_DEC   = 4'd12;

  typedef struct packed {
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } date_t;

  // Year is always inside 1900..2299 here, so the century rule
  // reduces to three excluded years.
  function automatic logic leap_year(input logic [11:0] yr);
    logic century_miss;
    century_miss = (yr == 12'd1900) || (yr == 12'd2100) || (yr == 12'd2200);
    return (yr[1:0] == 2'b00) && !century_miss;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mo,
                                              input logic [11:0] yr);
    logic [4:0] len;
    if (mo == MONTH_FEB) begin
      len = leap_year(yr) ? 5'd29 : 5'd28;
    end else if (mo == 4'd4 || mo == 4'd6 || mo == 4'd9 || mo == 4'd11) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage

// ===== hdl/cms_day_step.sv =====
// One-day step of weekday, day, month and year, forward or backward.
// Depends on cms_pkg.
module cms_day_step (
  input  cms_pkg::date_t cur,
  input  logic           fwd,
  input  logic           bwd,
  output cms_pkg::date_t nxt
);

  logic [4:0]  cur_len;
  logic [4:0]  prev_len;
  logic [3:0]  prev_month;
  logic [11:0] prev_year;

  assign cur_len = cms_pkg::month_length(cur.month, cur.year);

  // Month and year before the current one, with the window wrap.
  always_comb begin
    if (cur.month == cms_pkg::MONTH_JAN) begin
      prev_month = cms_pkg::MONTH_DEC;
      prev_year  = (cur.year == cms_pkg::YEAR_FIRST) ? cms_pkg::YEAR_LAST
                                                     : cur.year - 12'd1;
    end else begin
      prev_month = cur.month - 4'd1;
      prev_year  = cur.year;
    end
  end

  assign prev_len = cms_pkg::month_length(prev_month, prev_year);

  always_comb begin
    nxt = cur;
    if (fwd) begin
      nxt.weekday = (cur.weekday == cms_pkg::WEEKDAY_SUN) ? cms_pkg::WEEKDAY_MON
                                                          : cur.weekday + 3'd1;
      if (cur.day >= cur_len) begin
        nxt.day = 5'd1;
        if (cur.month == cms_pkg::MONTH_DEC) begin
          nxt.month = cms_pkg::MONTH_JAN;
          nxt.year  = (cur.year == cms_pkg::YEAR_LAST) ? cms_pkg::YEAR_FIRST
                                                       : cur.year + 12'd1;
        end else begin
          nxt.month = cur.month + 4'd1;
        end
      end else begin
        nxt.day = cur.day + 5'd1;
      end
    end else if (bwd) begin
      nxt.weekday = (cur.weekday == cms_pkg::WEEKDAY_MON) ? cms_pkg::WEEKDAY_SUN
                                                          : cur.weekday - 3'd1;
      if (cur.day == 5'd1) begin
        nxt.month = prev_month;
        nxt.year  = prev_year;
        nxt.day   = prev_len;
      end else begin
        nxt.day = cur.day - 5'd1;
      end
    end
  end

endmodule

// ===== hdl/calendar_minute_step_top.sv =====
// Top level of the calendar minute stepper: input register, carry logic,
// result register. Depends on cms_pkg and cms_day_step.
//
// Takes one broken-down time per beat and steps it one minute forward, one
// minute back, or converts local time to UTC (minus one hour in standard
// time, minus two in summer time; unknown and UTC pass through). Fields out
// of range are clamped first, except a day past the end of its month.
// Carries run through hour, weekday, day, month and year with Gregorian
// leap years; the year wraps inside 1900..2299. A pending DST switch at the
// hour boundary adds one extra hour step in standard time and cancels the
// step in summer time; if the hour sum then passes 24 or falls below -1,
// hour_fault is set and the hour is held at the edge with no day carry.
// An accepted beat waits in the input register until the result register
// is free or its result is taken, then passes the carry logic into it and
// result_valid rises. One beat is accepted per cycle as long as
// result_ready keeps up. A stalled result is held in the result register
// while the input register still takes one more beat.
module calendar_minute_step_top (
  input  logic        clk,
  input  logic        rst,

  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  operation,
  input  logic [5:0]  minute,
  input  logic [4:0]  hour,
  input  logic [2:0]  weekday,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [11:0] year,
  input  logic [1:0]  dst_state,
  input  logic        dst_change_due,

  output logic        result_valid,
  input  logic        result_ready,
  output logic [5:0]  new_minute,
  output logic [4:0]  new_hour,
  output logic [2:0]  new_weekday,
  output logic [4:0]  new_day,
  output logic [3:0]  new_month,
  output logic [11:0] new_year,
  output logic [1:0]  new_dst_state,
  output logic        hour_fault
);

  // ---------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------
  logic        stage_valid;
  logic [1:0]  stage_op;
  logic [5:0]  stage_minute;
  logic [4:0]  stage_hour;
  logic [2:0]  stage_weekday;
  logic [4:0]  stage_day;
  logic [3:0]  stage_month;
  logic [11:0] stage_year;
  logic [1:0]  stage_dst;
  logic        stage_due;

  logic advance;   // stage moves into the result register
  logic take;      // input beat accepted

  assign advance    = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || advance;
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_op      <= operation;
      stage_minute  <= minute;
      stage_hour    <= hour;
      stage_weekday <= weekday;
      stage_day     <= day;
      stage_month   <= month;
      stage_year    <= year;
      stage_dst     <= dst_state;
      stage_due     <= dst_change_due;
    end
  end

  // ---------------------------------------------------------------------
  // Clamp every field into its legal range
  // ---------------------------------------------------------------------
  logic [5:0]     mi;
  logic [4:0]     hr;
  cms_pkg::date_t date_in;

  always_comb begin
    mi = (stage_minute > cms_pkg::MINUTE_LAST) ? cms_pkg::MINUTE_LAST : stage_minute;
    hr = (stage_hour > cms_pkg::HOUR_LAST) ? cms_pkg::HOUR_LAST : stage_hour;
    date_in.weekday = (stage_weekday == 3'd0) ? cms_pkg::WEEKDAY_MON : stage_weekday;
    date_in.day     = (stage_day == 5'd0) ? 5'd1 : stage_day;
    if (stage_month == 4'd0) begin
      date_in.month = cms_pkg::MONTH_JAN;
    end else if (stage_month > cms_pkg::MONTH_DEC) begin
      date_in.month = cms_pkg::MONTH_DEC;
    end else begin
      date_in.month = stage_month;
    end
    if (stage_year < cms_pkg::YEAR_FIRST) begin
      date_in.year = cms_pkg::YEAR_FIRST;
    end else if (stage_year > cms_pkg::YEAR_LAST) begin
      date_in.year = cms_pkg::YEAR_LAST;
    end else begin
      date_in.year = stage_year;
    end
  end

  // ---------------------------------------------------------------------
  // Minute step and hour delta
  // The hour moves by -2..+2 in one beat, so it wraps at most once and the
  // date moves by at most one day.
  // ---------------------------------------------------------------------
  logic              utc_conv;
  logic              due_summer;
  logic              due_standard;
  logic [5:0]        mi_next;
  logic signed [2:0] delta;
  logic signed [6:0] hsum;
  logic [4:0]        hr_next;
  logic              day_fwd;
  logic              day_bwd;
  logic              fault_next;
  logic [1:0]        dst_next;

  assign utc_conv     = (stage_op == cms_pkg::OP_TO_UTC) &&
                        ((stage_dst == cms_pkg::DST_STANDARD) ||
                         (stage_dst == cms_pkg::DST_SUMMER));
  assign due_summer   = stage_due && (stage_dst == cms_pkg::DST_SUMMER);
  assign due_standard = stage_due && (stage_dst == cms_pkg::DST_STANDARD);

  always_comb begin
    mi_next = mi;
    delta   = 3'sd0;
    unique case (stage_op)
      cms_pkg::OP_ADD_MINUTE: begin
        if (mi == cms_pkg::MINUTE_LAST) begin
          mi_next = 6'd0;
          if (due_summer) begin
            delta = 3'sd0;
          end else if (due_standard) begin
            delta = 3'sd2;
          end else begin
            delta = 3'sd1;
          end
        end else begin
          mi_next = mi + 6'd1;
        end
      end
      cms_pkg::OP_SUB_MINUTE: begin
        if (mi == 6'd0) begin
          mi_next = cms_pkg::MINUTE_LAST;
          if (due_summer) begin
            delta = 3'sd0;
          end else if (due_standard) begin
            delta = -3'sd2;
          end else begin
            delta = -3'sd1;
          end
        end else begin
          mi_next = mi - 6'd1;
        end
      end
      cms_pkg::OP_TO_UTC: begin
        if (utc_conv) begin
          delta = (stage_dst == cms_pkg::DST_SUMMER) ? -3'sd2 : -3'sd1;
        end
      end
      default: begin
        mi_next = mi;
      end
    endcase
  end

  assign hsum = $signed({2'b00, hr}) + $signed({{4{delta[2]}}, delta});

  // Hour wrap, day carry and the two fault cases (DST switch in standard
  // time past midnight forward, or before midnight backward).
  always_comb begin
    hr_next    = hsum[4:0];
    day_fwd    = 1'b0;
    day_bwd    = 1'b0;
    fault_next = 1'b0;
    if (hsum == 7'sd24) begin
      hr_next = 5'd0;
      day_fwd = 1'b1;
    end else if (hsum > 7'sd24) begin
      hr_next    = cms_pkg::HOUR_LAST;
      fault_next = 1'b1;
    end else if (hsum < 7'sd0) begin
      if (utc_conv || hsum == -7'sd1) begin
        hr_next = 5'(hsum + 7'sd24);
        day_bwd = 1'b1;
      end else begin
        hr_next    = 5'd0;
        fault_next = 1'b1;
      end
    end
  end

  assign dst_next = utc_conv ? cms_pkg::DST_UTC : stage_dst;

  cms_pkg::date_t date_next;

  cms_day_step u_day_step (
    .cur (date_in),
    .fwd (day_fwd),
    .bwd (day_bwd),
    .nxt (date_next)
  );

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      new_minute    <= mi_next;
      new_hour      <= hr_next;
      new_weekday   <= date_next.weekday;
      new_day       <= date_next.day;
      new_month     <= date_next.month;
      new_year      <= date_next.year;
      new_dst_state <= dst_next;
      hour_fault    <= fault_next;
    end
  end

endmodule

// ===== dv/tb_calendar_minute_step_top.sv =====
// Self-checking testbench for calendar_minute_step_top: directed calendar corners,
// then biased random times under random idling on both sides of the block.
// Depends on cms_pkg and the RTL under hdl/.
package minute_step_tb_pkg;
  import cms_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [1:0]  dst;
    logic        due;
  } time_in_t;

  typedef struct packed {
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [1:0]  dst;
    logic        fault;
  } time_out_t;

  class minute_step_board;
    time_out_t predicted_times[$];
    int mismatches;
    int checked;
    int faults_seen;
    int utc_seen;

    static function bit is_leap(int yr);
      return (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
    endfunction

    static function int days_in_month(int mo, int yr);
      if (mo == 2) return is_leap(yr) ? 29 : 28;
      if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
      return 31;
    endfunction

    static function void next_day(inout int wd, inout int dy, inout int mo, inout int yr);
      wd = (wd == 7) ? 1 : wd + 1;
      dy++;
      if (dy > days_in_month(mo, yr)) begin
        dy = 1;
        mo++;
        if (mo == 13) begin
          mo = 1;
          yr++;
          if (yr > int'(YEAR_LAST)) yr = int'(YEAR_FIRST);
        end
      end
    endfunction

    static function void prev_day(inout int wd, inout int dy, inout int mo, inout int yr);
      wd = (wd == 1) ? 7 : wd - 1;
      if (dy == 1) begin
        mo--;
        if (mo == 0) begin
          mo = 12;
          yr--;
          if (yr < int'(YEAR_FIRST)) yr = int'(YEAR_LAST);
        end
        dy = days_in_month(mo, yr);
      end else begin
        dy--;
      end
    endfunction

    // Expected result of one time beat.
    static function time_out_t step_calendar(time_in_t it);
      int mi, hr, wd, dy, mo, yr, h;
      logic [1:0] dst;
      logic fault;
      mi = it.minute;
      if (mi > 59) mi = 59;
      hr = it.hour;
      if (hr > 23) hr = 23;
      wd = it.weekday;
      if (wd < 1) wd = 1;
      dy = it.day;
      if (dy < 1) dy = 1;
      mo = it.month;
      if (mo < 1) mo = 1;
      else if (mo > 12) mo = 12;
      yr = it.year;
      if (yr < int'(YEAR_FIRST)) yr = int'(YEAR_FIRST);
      else if (yr > int'(YEAR_LAST)) yr = int'(YEAR_LAST);
      dst = it.dst;
      fault = 1'b0;
      case (it.op)
        OP_ADD_MINUTE: begin
          if (mi == 59) begin
            mi = 0;
            h = hr;
            if (it.due) begin
              if (dst == DST_SUMMER) h--;
              else if (dst == DST_STANDARD) h++;
            end
            h++;
            if (h == 24) begin
              hr = 0;
              next_day(wd, dy, mo, yr);
            end else if (h > 23) begin
              fault = 1'b1;
              hr = 23;
            end else begin
              hr = h;
            end
          end else begin
            mi++;
          end
        end
        OP_SUB_MINUTE: begin
          if (mi == 0) begin
            mi = 59;
            h = hr;
            if (it.due) begin
              if (dst == DST_SUMMER) h++;
              else if (dst == DST_STANDARD) h--;
            end
            h--;
            if (h == -1) begin
              hr = 23;
              prev_day(wd, dy, mo, yr);
            end else if (h < 0) begin
              fault = 1'b1;
              hr = 0;
            end else begin
              hr = h;
            end
          end else begin
            mi--;
          end
        end
        OP_TO_UTC: begin
          if (dst == DST_STANDARD || dst == DST_SUMMER) begin
            repeat ((dst == DST_SUMMER) ? 2 : 1) begin
              if (hr == 0) begin
                hr = 23;
                prev_day(wd, dy, mo, yr);
              end else begin
                hr--;
              end
            end
            dst = DST_UTC;
          end
        end
        default: ;
      endcase
      return time_out_t'({6'(mi), 5'(hr), 3'(wd), 5'(dy), 4'(mo), 12'(yr), dst, fault});
    endfunction

    function void note_time(time_in_t it);
      predicted_times.push_back(step_calendar(it));
      if (it.op == OP_TO_UTC && (it.dst == DST_STANDARD || it.dst == DST_SUMMER)) utc_seen++;
    endfunction

    function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_time(time_out_t got);
      time_out_t want;
      if (predicted_times.size() == 0) begin
        $error("result beat with no prediction waiting (new_minute %0d, new_hour %0d)",
               got.minute, got.hour);
        mismatches++;
        return;
      end
      want = predicted_times.pop_front();
      checked++;
      if (want.fault) faults_seen++;
      compare_field("new_minute", want.minute, got.minute);
      compare_field("new_hour", want.hour, got.hour);
      compare_field("new_weekday", want.weekday, got.weekday);
      compare_field("new_day", want.day, got.day);
      compare_field("new_month", want.month, got.month);
      compare_field("new_year", want.year, got.year);
      compare_field("new_dst_state", want.dst, got.dst);
      compare_field("hour_fault", want.fault, got.fault);
    endfunction

    function int outstanding();
      return predicted_times.size();
    endfunction
  endclass
endpackage

module tb_calendar_minute_step_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cms_pkg::*;
  import minute_step_tb_pkg::*;

  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT  = 200000;
  // Output hold-off long enough to back up both pipeline registers.
  localparam int STALL_CYCLES = 300;
  localparam int STALL_AFTER  = 250;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  logic [1:0]  operation;
  logic [5:0]  minute;
  logic [4:0]  hour;
  logic [2:0]  weekday;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  logic [1:0]  dst_state;
  logic        dst_change_due;
  logic        result_valid;
  logic        result_ready;
  logic [5:0]  new_minute;
  logic [4:0]  new_hour;
  logic [2:0]  new_weekday;
  logic [4:0]  new_day;
  logic [3:0]  new_month;
  logic [11:0] new_year;
  logic [1:0]  new_dst_state;
  logic        hour_fault;

  minute_step_board board = new();

  int items_taken;   // input beats accepted so far
  int cycles;
  bit burst;         // no idling on either side while set
  bit stall_done;

  calendar_minute_step_top u_top (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .operation      (operation),
    .minute         (minute),
    .hour           (hour),
    .weekday        (weekday),
    .day            (day),
    .month          (month),
    .year           (year),
    .dst_state      (dst_state),
    .dst_change_due (dst_change_due),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .new_minute     (new_minute),
    .new_hour       (new_hour),
    .new_weekday    (new_weekday),
    .new_day        (new_day),
    .new_month      (new_month),
    .new_year       (new_year),
    .new_dst_state  (new_dst_state),
    .hour_fault     (hour_fault)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic time_in_t stamp(input logic [1:0] op, input int mi, input int hr,
                                     input int wd, input int dy, input int mo, input int yr,
                                     input logic [1:0] dst, input logic due);
    return time_in_t'({op, 6'(mi), 5'(hr), 3'(wd), 5'(dy), 4'(mo), 12'(yr), dst, due});
  endfunction

  // Random time. Most are legal dates biased toward minute, hour, month and
  // year boundaries so carries reach all the way up; a slice is raw bits to
  // exercise clamping and toggle every input bit.
  function automatic time_in_t random_time();
    time_in_t it;
    int shape;
    int len;
    shape = $urandom_range(0, 99);
    it.op  = ($urandom_range(0, 24) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
    it.dst = 2'($urandom_range(0, 3));
    it.due = 1'($urandom_range(0, 1));
    if (shape < 12) begin
      it.minute  = 6'($urandom);
      it.hour    = 5'($urandom);
      it.weekday = 3'($urandom);
      it.day     = 5'($urandom);
      it.month   = 4'($urandom);
      it.year    = 12'($urandom);
      return it;
    end
    it.weekday = 3'($urandom_range(1, 7));
    case ($urandom_range(0, 5))
      0:       it.year = YEAR_FIRST;
      1:       it.year = YEAR_LAST;
      2:       it.year = 12'd2000;
      3:       it.year = 12'(1900 + 4 * $urandom_range(0, 99));
      default: it.year = 12'($urandom_range(1900, 2299));
    endcase
    it.month = 4'($urandom_range(1, 12));
    // Midnight at a month edge; a third of them at the year edge.
    if (shape < 40 && $urandom_range(0, 2) == 0) begin
      it.month = $urandom_range(0, 1) ? MONTH_DEC : MONTH_JAN;
    end
    len = minute_step_board::days_in_month(it.month, it.year);
    case ($urandom_range(0, 4))
      0:       it.day = 5'd1;
      1:       it.day = 5'(len);
      2, 3:    it.day = 5'($urandom_range(1, len));
      default: it.day = 5'($urandom_range(len, 31));  // may run past month end
    endcase
    case ($urandom_range(0, 3))
      0:       it.minute = 6'd0;
      1:       it.minute = MINUTE_LAST;
      default: it.minute = 6'($urandom_range(0, 59));
    endcase
    case ($urandom_range(0, 5))
      0:       it.hour = 5'd0;
      1:       it.hour = 5'd1;
      2:       it.hour = 5'd22;
      3:       it.hour = HOUR_LAST;
      default: it.hour = 5'($urandom_range(0, 23));
    endcase
    if (shape < 40) begin
      if ($urandom_range(0, 1)) begin
        it.hour   = HOUR_LAST;
        it.minute = MINUTE_LAST;
        it.day    = 5'(len);
      end else begin
        it.hour   = 5'($urandom_range(0, 1));
        it.minute = 6'd0;
        it.day    = 5'd1;
      end
    end
    return it;
  endfunction

  // Offer one beat. Valid only drops when a gap precedes the beat, so a
  // back-to-back beat never sees valid lowered and raised in one step.
  task automatic offer_time(input time_in_t it);
    int gap;
    gap = burst ? 0 : idle_cycles();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {operation, minute, hour, weekday, day, month, year, dst_state, dst_change_due} <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  // Both monitors sample at the edge, so they see the values the block saw.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      board.note_time(time_in_t'({operation, minute, hour, weekday, day, month, year,
                                  dst_state, dst_change_due}));
      items_taken++;
    end
    if (!rst && result_valid && result_ready) begin
      board.check_time(time_out_t'({new_minute, new_hour, new_weekday, new_day, new_month,
                                    new_year, new_dst_state, hour_fault}));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("calendar_minute_step_top test failed");
      $finish;
    end
  end

  // Result side: random back-pressure, solid ready in bursts, and one long
  // hold-off partway through while the sender keeps offering beats.
  initial begin
    int gap;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!stall_done && items_taken >= STALL_AFTER) begin
        stall_done = 1'b1;
        result_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else if (burst) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = idle_cycles();
        if (gap > 0) begin
          result_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    item_valid     <= 1'b0;
    operation      <= OP_ADD_MINUTE;
    minute         <= '0;
    hour           <= '0;
    weekday        <= WEEKDAY_MON;
    day            <= 5'd1;
    month          <= MONTH_JAN;
    year           <= YEAR_FIRST;
    dst_state      <= DST_STANDARD;
    dst_change_due <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed corners.
    offer_time(stamp(OP_ADD_MINUTE, 30, 12, 3, 15, 6, 2024, DST_SUMMER, 1'b0));
    offer_time(stamp(OP_SUB_MINUTE, 30, 12, 3, 15, 6, 2024, DST_SUMMER, 1'b1));
    // Year wraps forward at the top of the window, and back at the bottom.
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 7, 31, 12, 2299, DST_STANDARD, 1'b0));
    offer_time(stamp(OP_SUB_MINUTE, 0, 0, 1, 1, 1, 1900, DST_STANDARD, 1'b0));
    // DST switch pushing the hour out of range both ways.
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 5, 30, 10, 2021, DST_STANDARD, 1'b1));
    offer_time(stamp(OP_SUB_MINUTE, 0, 0, 5, 30, 10, 2021, DST_STANDARD, 1'b1));
    // DST switch landing exactly on a day carry or borrow.
    offer_time(stamp(OP_ADD_MINUTE, 59, 22, 6, 28, 2, 2023, DST_STANDARD, 1'b1));
    offer_time(stamp(OP_SUB_MINUTE, 0, 1, 1, 1, 3, 2024, DST_STANDARD, 1'b1));
    // Summer-time switch cancels the step.
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 7, 27, 3, 2022, DST_SUMMER, 1'b1));
    offer_time(stamp(OP_SUB_MINUTE, 0, 2, 7, 27, 3, 2022, DST_SUMMER, 1'b1));
    offer_time(stamp(OP_ADD_MINUTE, 59, 5, 2, 10, 4, 2050, DST_UNKNOWN, 1'b1));
    // UTC conversion across leap and non-leap February ends.
    offer_time(stamp(OP_TO_UTC, 30, 0, 3, 1, 3, 2000, DST_STANDARD, 1'b0));
    offer_time(stamp(OP_TO_UTC, 10, 1, 1, 1, 3, 2100, DST_SUMMER, 1'b0));
    offer_time(stamp(OP_TO_UTC, 10, 1, 1, 1, 1, 1900, DST_SUMMER, 1'b1));
    offer_time(stamp(OP_TO_UTC, 45, 0, 4, 1, 1, 2010, DST_UNKNOWN, 1'b0));
    offer_time(stamp(OP_TO_UTC, 45, 0, 4, 1, 1, 2010, DST_UTC, 1'b0));
    offer_time(stamp(OP_UNUSED, 59, 23, 7, 31, 12, 2299, DST_STANDARD, 1'b1));
    // Day past the end of a short month carries on the next day step.
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 4, 31, 4, 2030, DST_UNKNOWN, 1'b0));
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 4, 30, 2, 2001, DST_UTC, 1'b0));
    offer_time(stamp(OP_ADD_MINUTE, 59, 23, 6, 28, 2, 2004, DST_UTC, 1'b0));
    offer_time(stamp(OP_SUB_MINUTE, 0, 0, 1, 1, 3, 2004, DST_UTC, 1'b0));
    // Clamping: everything at all-ones, then all-zeros.
    offer_time(stamp(OP_ADD_MINUTE, 63, 31, 7, 31, 15, 4095, DST_UTC, 1'b1));
    offer_time(stamp(OP_UNUSED, 63, 31, 7, 31, 15, 4095, DST_UTC, 1'b1));
    offer_time(stamp(OP_ADD_MINUTE, 0, 0, 0, 0, 0, 0, DST_STANDARD, 1'b0));
    offer_time(stamp(OP_SUB_MINUTE, 0, 0, 0, 0, 0, 0, DST_STANDARD, 1'b0));

    // Random phase; every hundred beats the last thirty run with no idling.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      burst = (n % 100) >= 70;
      offer_time(random_time());
    end
    burst = 1'b0;
    item_valid <= 1'b0;

    do @(posedge clk); while (board.outstanding() != 0);
    // Two-stage pipe; give any stray beat time to show up.
    repeat (10) @(posedge clk);

    $display("Checked %0d minute steps: directed calendar corners plus random times,",
             board.checked);
    $display("%0d DST hour faults, %0d UTC conversions, one %0d-cycle output hold-off.",
             board.faults_seen, board.utc_seen, STALL_CYCLES);
    if (board.mismatches == 0) begin
      $display("calendar_minute_step_top test passed");
    end else begin
      $display("calendar_minute_step_top test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cms_pkg.sv
hdl/cms_day_step.sv
hdl/calendar_minute_step_top.sv
dv/tb_calendar_minute_step_top.sv
